/* rtl/rqs_pkg.sv */
`default_nettype none
package rqs_pkg;

   localparam int READY_DEPTH = 16;
   localparam int CPU_MAX     = 4;
   localparam int ADDR_W      = $clog2(READY_DEPTH);
   localparam int CNT_W       = $clog2(READY_DEPTH + 1);
   localparam int CPU_W       = 2;
   localparam int NCPU_W      = 3;
   localparam int ENTRY_W     = 16;

   localparam logic [2:0] MODE_WAKE      = 3'd0;
   localparam logic [2:0] MODE_PREEMPT   = 3'd1;
   localparam logic [2:0] MODE_YIELD     = 3'd2;
   localparam logic [2:0] MODE_TERMINATE = 3'd3;
   localparam logic [2:0] MODE_IDLE      = 3'd4;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_FULL     = 2'd1;
   localparam logic [1:0] ERR_NO_PROC  = 2'd2;

   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_CPUS   = 1'b1;

   typedef struct packed {
      logic [2:0] mode;
      logic [1:0] cpu_index;
      logic [7:0] proc_id;
      logic [7:0] proc_priority;
   } req_type;

   typedef struct packed {
      logic       dispatched;
      logic [7:0] dispatch_pid;
      logic       preempt_request;
      logic [1:0] preempt_cpu;
      logic [1:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic              policy;
      logic [NCPU_W-1:0] cpus_in_use;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCHED,
      ST_SCAN,
      ST_PICK,
      ST_SHIFT,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

/* rtl/rqs_ram.sv */
`default_nettype none
module rqs_ram #(
   parameter int DATA_W = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem [(1 << ADDR_W)];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

/* rtl/rqs_ctrl.sv */
`default_nettype none
module rqs_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rqs_pkg::cfg_type              cfg,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire rqs_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output rqs_pkg::rsp_type                   rsp_data,
   output logic                               mem_we,
   output logic [rqs_pkg::ADDR_W-1:0]         mem_waddr,
   output logic [rqs_pkg::ENTRY_W-1:0]        mem_wdata,
   output logic [rqs_pkg::ADDR_W-1:0]         mem_raddr,
   input  wire logic [rqs_pkg::ENTRY_W-1:0]   mem_rdata
);
   rqs_pkg::state_type state_ff, state_in;
   rqs_pkg::req_type   req_ff, req_in;
   rqs_pkg::rsp_type   res_ff, res_in;
   rqs_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [rqs_pkg::ADDR_W-1:0] head_ff, head_in;
   logic [rqs_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [rqs_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [rqs_pkg::ADDR_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [rqs_pkg::ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic [7:0]                 best_pid_ff, best_pid_in;
   logic [7:0]                 best_prio_ff, best_prio_in;

   logic [rqs_pkg::CPU_MAX-1:0] run_valid_ff, run_valid_in;
   logic [7:0] run_pid_ff  [rqs_pkg::CPU_MAX];
   logic [7:0] run_pid_in  [rqs_pkg::CPU_MAX];
   logic [7:0] run_prio_ff [rqs_pkg::CPU_MAX];
   logic [7:0] run_prio_in [rqs_pkg::CPU_MAX];

   logic [rqs_pkg::NCPU_W-1:0] ncpu;
   logic                       served;
   logic                       full;
   logic                       out_free;
   logic                       all_busy, found;
   logic [7:0]                 low;
   logic [rqs_pkg::CPU_W-1:0]  low_cpu;
   logic [7:0]                 cur_pid, cur_prio;
   logic                       better;

   always_comb begin
      if (cfg.cpus_in_use == '0) begin
         ncpu = rqs_pkg::NCPU_W'(1);
      end else if (cfg.cpus_in_use > rqs_pkg::NCPU_W'(rqs_pkg::CPU_MAX)) begin
         ncpu = rqs_pkg::NCPU_W'(rqs_pkg::CPU_MAX);
      end else begin
         ncpu = cfg.cpus_in_use;
      end
   end

   assign served   = {1'b0, req_ff.cpu_index} < ncpu;
   assign full     = count_ff == rqs_pkg::CNT_W'(rqs_pkg::READY_DEPTH);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cur_pid  = mem_rdata[15:8];
   assign cur_prio = mem_rdata[7:0];
   assign better   = cfg.policy ? (cur_prio > best_prio_ff) : (cur_pid < best_pid_ff);

   // victim search for priority preemption: first lowest running priority
   always_comb begin
      all_busy = 1'b1;
      found    = 1'b0;
      low      = req_ff.proc_priority;
      low_cpu  = '0;
      for (int i = 0; i < rqs_pkg::CPU_MAX; i++) begin
         if (rqs_pkg::NCPU_W'(i) < ncpu) begin
            if (!run_valid_ff[i]) begin
               all_busy = 1'b0;
            end else if (run_prio_ff[i] < low) begin
               low     = run_prio_ff[i];
               low_cpu = rqs_pkg::CPU_W'(i);
               found   = 1'b1;
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rqs_pkg::ST_IDLE: begin
            if (req_valid) state_in = rqs_pkg::ST_EXEC;
         end
         rqs_pkg::ST_EXEC: begin
            state_in = rqs_pkg::ST_DONE;
            if (req_ff.mode != rqs_pkg::MODE_WAKE && served) begin
               case (req_ff.mode) inside
                  rqs_pkg::MODE_PREEMPT: begin
                     if (run_valid_ff[req_ff.cpu_index] && !full)
                        state_in = rqs_pkg::ST_SCHED;
                  end
                  rqs_pkg::MODE_YIELD, rqs_pkg::MODE_TERMINATE: begin
                     if (run_valid_ff[req_ff.cpu_index]) state_in = rqs_pkg::ST_SCHED;
                  end
                  rqs_pkg::MODE_IDLE: state_in = rqs_pkg::ST_SCHED;
                  default: state_in = rqs_pkg::ST_DONE;
               endcase
            end
         end
         rqs_pkg::ST_SCHED: begin
            state_in = (count_ff == '0) ? rqs_pkg::ST_DONE : rqs_pkg::ST_SCAN;
         end
         rqs_pkg::ST_SCAN: begin
            if (idx_ff == count_ff) state_in = rqs_pkg::ST_PICK;
         end
         rqs_pkg::ST_PICK: begin
            state_in = ({1'b0, best_idx_ff} == count_ff - 1'b1) ?
                       rqs_pkg::ST_DONE : rqs_pkg::ST_SHIFT;
         end
         rqs_pkg::ST_SHIFT: begin
            if (idx_ff + rqs_pkg::CNT_W'(2) >= count_ff) state_in = rqs_pkg::ST_DONE;
         end
         rqs_pkg::ST_DONE: begin
            if (out_free) state_in = rqs_pkg::ST_IDLE;
         end
         default: state_in = rqs_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_idx_in  = best_idx_ff;
      best_pid_in  = best_pid_ff;
      best_prio_in = best_prio_ff;
      run_valid_in = run_valid_ff;
      run_pid_in   = run_pid_ff;
      run_prio_in  = run_prio_ff;
      mem_we       = 1'b0;
      mem_waddr    = head_ff - 1'b1;
      mem_wdata    = {req_ff.proc_id, req_ff.proc_priority};
      mem_raddr    = head_ff;
      req_stall    = state_ff != rqs_pkg::ST_IDLE;

      unique case (state_ff)
         rqs_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
            end
         end
         rqs_pkg::ST_EXEC: begin
            if (req_ff.mode == rqs_pkg::MODE_WAKE) begin
               if (full) begin
                  res_in.error_code = rqs_pkg::ERR_FULL;
               end else begin
                  mem_we   = 1'b1;
                  head_in  = head_ff - 1'b1;
                  count_in = count_ff + 1'b1;
                  if (cfg.policy && all_busy && found) begin
                     res_in.preempt_request = 1'b1;
                     res_in.preempt_cpu     = low_cpu;
                  end
               end
            end else if (served) begin
               case (req_ff.mode) inside
                  rqs_pkg::MODE_PREEMPT: begin
                     if (!run_valid_ff[req_ff.cpu_index]) begin
                        res_in.error_code = rqs_pkg::ERR_NO_PROC;
                     end else if (full) begin
                        res_in.error_code = rqs_pkg::ERR_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = {run_pid_ff[req_ff.cpu_index],
                                     run_prio_ff[req_ff.cpu_index]};
                        head_in   = head_ff - 1'b1;
                        count_in  = count_ff + 1'b1;
                        run_valid_in[req_ff.cpu_index] = 1'b0;
                     end
                  end
                  rqs_pkg::MODE_YIELD, rqs_pkg::MODE_TERMINATE: begin
                     if (!run_valid_ff[req_ff.cpu_index])
                        res_in.error_code = rqs_pkg::ERR_NO_PROC;
                     else
                        run_valid_in[req_ff.cpu_index] = 1'b0;
                  end
                  rqs_pkg::MODE_IDLE: run_valid_in[req_ff.cpu_index] = 1'b0;
                  default: res_in = '0;
               endcase
            end
         end
         rqs_pkg::ST_SCHED: begin
            // read logical entry 0; compare starts next cycle
            mem_raddr  = head_ff;
            idx_in     = rqs_pkg::CNT_W'(1);
            cmp_idx_in = '0;
         end
         rqs_pkg::ST_SCAN: begin
            if (cmp_idx_ff == '0 || better) begin
               best_idx_in  = cmp_idx_ff;
               best_pid_in  = cur_pid;
               best_prio_in = cur_prio;
            end
            mem_raddr  = head_ff + idx_ff[rqs_pkg::ADDR_W-1:0];
            cmp_idx_in = idx_ff[rqs_pkg::ADDR_W-1:0];
            if (idx_ff != count_ff) idx_in = idx_ff + 1'b1;
         end
         rqs_pkg::ST_PICK: begin
            run_valid_in[req_ff.cpu_index] = 1'b1;
            run_pid_in[req_ff.cpu_index]   = best_pid_ff;
            run_prio_in[req_ff.cpu_index]  = best_prio_ff;
            res_in.dispatched   = 1'b1;
            res_in.dispatch_pid = best_pid_ff;
            mem_raddr = head_ff + best_idx_ff + 1'b1;
            idx_in    = {1'b0, best_idx_ff};
            if ({1'b0, best_idx_ff} == count_ff - 1'b1) count_in = count_ff - 1'b1;
         end
         rqs_pkg::ST_SHIFT: begin
            // close the gap: entry k takes entry k+1, next read is k+2
            mem_we    = 1'b1;
            mem_waddr = head_ff + idx_ff[rqs_pkg::ADDR_W-1:0];
            mem_wdata = mem_rdata;
            mem_raddr = head_ff + idx_ff[rqs_pkg::ADDR_W-1:0] + rqs_pkg::ADDR_W'(2);
            if (idx_ff + rqs_pkg::CNT_W'(2) >= count_ff)
               count_in = count_ff - 1'b1;
            else
               idx_in = idx_ff + 1'b1;
         end
         rqs_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rqs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         run_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         run_valid_ff <= run_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
      idx_ff       <= idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_pid_ff  <= best_pid_in;
      best_prio_ff <= best_prio_in;
      run_pid_ff   <= run_pid_in;
      run_prio_ff  <= run_prio_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

/* rtl/ready_queue_cpu_scheduler.sv */
// Ready-queue CPU scheduler with optional static-priority preemption.
// Request channel (req_valid/req_stall/req_data): one scheduling event each
// (wake, preempt, yield, terminate, idle). Response channel (rsp_valid/
// rsp_stall/rsp_data): exactly one response per request, in order.
// CSR port (APB style, pready tied high): 0x0 policy, 0x4 cpus_in_use.
// Write CSRs only while no request is outstanding.
// Timing: one request at a time; req_stall is high from accept until the
// response is loaded into the output register.
// The ready-list RAM has one read port, so the scan reads one entry
// a cycle and removal moves one entry a cycle toward the head.
// The list lives in a circular RAM (head pointer + count); running table
// is four registers. Reset empties the list and idles all CPUs at once,
// no clearing pass. A stalled response holds in the output register while
// the next request is accepted and worked on.
`default_nettype none
module ready_queue_cpu_scheduler (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rqs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rqs_pkg::rsp_type      rsp_data,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   rqs_pkg::cfg_type cfg_ff, cfg_in;

   logic                        mem_we;
   logic [rqs_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [rqs_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

   // CSR write decode on register index (paddr bit 2)
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            rqs_pkg::REG_POLICY: cfg_in.policy      = csr_pwdata[0];
            rqs_pkg::REG_CPUS:   cfg_in.cpus_in_use = csr_pwdata[rqs_pkg::NCPU_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy      <= 1'b0;
         cfg_ff.cpus_in_use <= rqs_pkg::NCPU_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         rqs_pkg::REG_POLICY: csr_prdata = {31'd0, cfg_ff.policy};
         rqs_pkg::REG_CPUS:   csr_prdata = {29'd0, cfg_ff.cpus_in_use};
         default:             csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   rqs_ram #(
      .DATA_W (rqs_pkg::ENTRY_W),
      .ADDR_W (rqs_pkg::ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   rqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );
endmodule
`default_nettype wire
